>>> rtl/frd_pkg.sv
// Package for the fuel refill event detector: widths, register indexes, record kinds.
// No dependencies.
`default_nettype none
package frd_pkg;
	localparam int SampleDepth = 5;
	localparam int SlotW = $clog2(SampleDepth);
	localparam int CntW = $clog2(SampleDepth + 1);
	localparam int LevelW = 7;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ENABLE = 3'd0,
		REG_INTERVAL = 3'd1,
		REG_HOLDOFF = 3'd2,
		REG_SPREAD = 3'd3,
		REG_INCREASE = 3'd4,
		REG_DECREASE = 3'd5
	} reg_idx_t;

	localparam logic KIND_CHECKPOINT = 1'b0;
	localparam logic KIND_REFILL = 1'b1;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [7:0] fuel_level;
		logic ignition;
		logic [23:0] odometer;
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tick_t;

	typedef struct packed {
		logic record_kind;
		logic [6:0] before_percent;
		logic [6:0] after_percent;
		logic [23:0] record_odometer;
		logic last_of_run;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SORT, ST_DECIDE, ST_OUT1, ST_OUT2
	} state_t;

	// Sort cell control: load the ring, or run one odd/even transposition step.
	typedef struct packed {
		logic load;
		logic step;
		logic odd;
	} sort_ctl_t;
endpackage
`default_nettype wire

>>> rtl/frd_if.sv
// Valid/ready channel interfaces for ticks and records.
// Depends on frd_pkg.
`default_nettype none
interface frd_tick_if;
	logic valid;
	logic ready;
	frd_pkg::tick_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface frd_rec_if;
	logic valid;
	logic ready;
	frd_pkg::rec_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/frd_cell.sv
// One sort cell: holds a sample and compare-exchanges with its right or left neighbor, by step parity.
// Depends on frd_pkg.
`default_nettype none
module frd_cell (
	input wire logic clk,
	input wire frd_pkg::sort_ctl_t ctl,
	input wire logic is_even,
	input wire logic [frd_pkg::LevelW-1:0] load_val,
	input wire logic [frd_pkg::LevelW-1:0] left_val,
	input wire logic [frd_pkg::LevelW-1:0] right_val,
	input wire logic has_left,
	input wire logic has_right,
	output logic [frd_pkg::LevelW-1:0] val_q
);
	import frd_pkg::*;
	logic lead;
	assign lead = (is_even != ctl.odd);
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= load_val;
		end else if (ctl.step) begin
			if (lead && has_right && right_val < val_q) val_q <= right_val;
			else if (!lead && has_left && left_val > val_q) val_q <= left_val;
		end
	end
endmodule
`default_nettype wire

>>> rtl/fuel_refill_event_detector_core.sv
// Top level of the fuel refill event detector: control, sample ring, sort cells, records.
// Depends on frd_pkg, frd_if and frd_cell.
//
// Channel   Dir  Payload
// tick      in   tick_t: time, level, ignition, odometer, wall clock
// rec       out  rec_t: kind, before, after, odometer, last flag
// cfg       in   we, idx, wdata
//
// An item that leaves a full ring is loaded into the sort cells, runs SampleDepth odd/even
// steps there and then passes a decision state; other items need no sort.
// Records leave through an output register, one per beat; the next tick is taken
// once the last record is taken. arst_n clears all control state at once.
`default_nettype none
module fuel_refill_event_detector_core (
	input wire logic clk,
	input wire logic arst_n,
	frd_tick_if.sink tick,
	frd_rec_if.source rec,
	input wire logic we,
	input wire logic [frd_pkg::CfgIdxW-1:0] idx,
	input wire logic [frd_pkg::CfgDataW-1:0] wdata
);
	import frd_pkg::*;

	logic en_q;
	logic [15:0] interval_q, holdoff_q;
	logic [6:0] spread_q, inc_q, dec_q;
	logic [LevelW-1:0] ring_q [SampleDepth];
	logic [SlotW-1:0] slot_q;
	logic [CntW-1:0] fill_q;
	logic [31:0] last_t_q;
	logic prev_ign_q, ign_seen_q, start_done_q, off_done_q;
	logic cp_valid_q, rf_valid_q;
	logic [6:0] cp_lvl_q, rf_before_q, rf_after_q;
	logic [23:0] rf_odo_q;
	state_t st_q, st_d;
	logic [CntW-1:0] step_q;
	logic ign_q;
	logic [23:0] odo_q;
	rec_t r2_q;
	logic two_q;
	logic out_valid_q;
	rec_t out_q;
	sort_ctl_t ctl;
	logic [LevelW-1:0] cv [SampleDepth];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; interval_q <= 16'd1000; holdoff_q <= 16'd5000;
			spread_q <= 7'd2; inc_q <= 7'd10; dec_q <= 7'd5;
		end else if (we) begin
			case (reg_idx_t'(idx))
				REG_ENABLE: en_q <= wdata[0];
				REG_INTERVAL: interval_q <= wdata;
				REG_HOLDOFF: holdoff_q <= wdata;
				REG_SPREAD: spread_q <= wdata[6:0];
				REG_INCREASE: inc_q <= wdata[6:0];
				REG_DECREASE: dec_q <= wdata[6:0];
				default: ;
			endcase
		end
	end

	// Front end evaluation for the item at the port.
	tick_t tk;
	logic clk_ok, bad, ign_chg, take, full_after;
	logic [31:0] dt;
	assign tk = tick.data;
	assign clk_ok = tk.year >= 12'd2020 && tk.year <= 12'd2099 && tk.month >= 4'd1
		&& tk.month <= 4'd12 && tk.day >= 5'd1 && tk.hour <= 5'd23
		&& tk.minute <= 6'd59 && tk.second <= 6'd59;
	assign bad = !clk_ok || tk.fuel_level > 8'd100 || tk.time_ms <= {16'd0, holdoff_q};
	assign ign_chg = ign_seen_q && (tk.ignition != prev_ign_q);
	assign dt = tk.time_ms - last_t_q;
	assign take = !((last_t_q != 32'd0 && !ign_chg) && dt < {16'd0, interval_q});
	logic [CntW-1:0] fill_base;
	logic [SlotW-1:0] slot_base;
	assign fill_base = ign_chg ? '0 : fill_q;
	assign slot_base = ign_chg ? '0 : slot_q;
	assign full_after = tk.ignition ? (fill_base >= CntW'(SampleDepth - 1))
		: (fill_base == CntW'(SampleDepth));

	assign tick.ready = (st_q == ST_IDLE) && !out_valid_q;
	logic acc;
	assign acc = tick.valid && tick.ready;

	// Sorted values: min, max, median.
	logic [LevelW-1:0] lvl;
	logic stable;
	assign lvl = cv[SampleDepth/2];
	assign stable = ({1'b0, cv[SampleDepth-1]} - {1'b0, cv[0]}) <= {1'b0, spread_q};

	logic [7:0] lvl_inc, lvl_dec;
	assign lvl_inc = {1'b0, cp_lvl_q} + {1'b0, inc_q};
	assign lvl_dec = {1'b0, lvl} + {1'b0, dec_q};
	logic up, down, dup;
	assign up = {1'b0, lvl} >= lvl_inc;
	assign down = {1'b0, cp_lvl_q} >= lvl_dec;
	logic [23:0] odiff;
	assign odiff = rf_odo_q > odo_q ? rf_odo_q - odo_q : odo_q - rf_odo_q;
	assign dup = rf_valid_q && rf_before_q == cp_lvl_q && rf_after_q == lvl
		&& odiff <= 24'd10;

	// Load the cells in the first sort cycle from the ring just written.
	always_comb begin
		st_d = st_q;
		ctl = '0;
		ctl.odd = step_q[0];
		case (st_q)
			ST_IDLE: if (acc && en_q && !bad && take && full_after) st_d = ST_SORT;
			ST_SORT: begin
				ctl.load = (step_q == '0);
				ctl.step = 1'b1;
				if (step_q == CntW'(SampleDepth)) st_d = ST_DECIDE;
			end
			ST_DECIDE: st_d = ST_IDLE;
			ST_OUT1: st_d = ST_IDLE;
			ST_OUT2: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	rec_t cp_rec, rf_rec;
	always_comb begin
		cp_rec = '{KIND_CHECKPOINT, lvl, lvl, odo_q, 1'b1};
		rf_rec = '{KIND_REFILL, cp_lvl_q, lvl, odo_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; step_q <= '0; slot_q <= '0; fill_q <= '0; last_t_q <= '0;
			prev_ign_q <= 1'b0; ign_seen_q <= 1'b0; start_done_q <= 1'b0;
			off_done_q <= 1'b0; cp_valid_q <= 1'b0; cp_lvl_q <= '0; rf_valid_q <= 1'b0;
			rf_before_q <= '0; rf_after_q <= '0; rf_odo_q <= '0;
			out_valid_q <= 1'b0; two_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid_q && rec.ready) begin
				out_valid_q <= two_q;
				two_q <= 1'b0;
				out_q <= r2_q;
			end
			if (st_q == ST_SORT) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (acc && en_q) begin
				if (bad) begin
					slot_q <= '0; fill_q <= '0;
				end else begin
					if (!ign_seen_q) begin
						prev_ign_q <= tk.ignition; ign_seen_q <= 1'b1;
					end else if (ign_chg) begin
						prev_ign_q <= tk.ignition; off_done_q <= 1'b0;
						if (tk.ignition) start_done_q <= 1'b0;
					end
					if (take) begin
						last_t_q <= tk.time_ms;
						if (tk.ignition) begin
							slot_q <= (slot_base == SlotW'(SampleDepth - 1)) ? '0
								: slot_base + 1'b1;
							fill_q <= (fill_base == CntW'(SampleDepth)) ? fill_base
								: fill_base + 1'b1;
						end else if (ign_chg) begin
							slot_q <= '0; fill_q <= '0;
						end
					end
					ign_q <= tk.ignition;
					odo_q <= tk.odometer;
				end
			end
			if (st_q == ST_DECIDE && stable) begin
				if (ign_q && !start_done_q) begin
					start_done_q <= 1'b1;
					if (!cp_valid_q || up || down) begin
						cp_valid_q <= 1'b1; cp_lvl_q <= lvl;
						out_valid_q <= 1'b1;
						out_q <= (cp_valid_q && up && !dup) ? rf_rec : cp_rec;
						if (cp_valid_q && up && !dup) begin
							rf_valid_q <= 1'b1; rf_before_q <= cp_lvl_q;
							rf_after_q <= lvl; rf_odo_q <= odo_q;
							r2_q <= cp_rec; two_q <= 1'b1;
						end
					end
				end else if (!ign_q && !off_done_q) begin
					off_done_q <= 1'b1;
					if (cp_valid_q && down) begin
						cp_valid_q <= 1'b1; cp_lvl_q <= lvl;
						out_valid_q <= 1'b1; out_q <= cp_rec;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && en_q && !bad && take && tk.ignition)
			ring_q[slot_base] <= tk.fuel_level[6:0];
	end

	for (genvar g = 0; g < SampleDepth; g++) begin : g_cell
		frd_cell u_cell (
			.clk(clk), .ctl(ctl), .is_even(g % 2 == 0),
			.load_val(ring_q[g]),
			.left_val(cv[(g == 0) ? 0 : g - 1]),
			.right_val(cv[(g == SampleDepth - 1) ? g : g + 1]),
			.has_left(g != 0), .has_right(g != SampleDepth - 1),
			.val_q(cv[g])
		);
	end

	assign rec.valid = out_valid_q;
	assign rec.data = out_q;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tick.ready |-> (st_q == ST_IDLE)) else $error("ready outside idle");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(SampleDepth)) else $error("fill count overflow");
	a_two_hold: assert property (@(posedge clk) disable iff (!arst_n)
		two_q |-> out_valid_q) else $error("second record without first");
`endif
endmodule
`default_nettype wire

>>> verif/frd_record_scoreboard.sv
`timescale 1ns / 1ps
// Record scoreboard for the fuel refill event detector: tracks register writes and accepted
// ticks, predicts the checkpoint and refill records, and compares every record beat.
// Depends on frd_pkg and the channel interfaces in frd_if.
module frd_record_scoreboard (
	input logic clk,
	input logic we,
	input logic [frd_pkg::CfgIdxW-1:0] idx,
	input logic [frd_pkg::CfgDataW-1:0] wdata,
	frd_tick_if tick,
	frd_rec_if rec,
	output int errors,
	output int pending,
	output int n_ticks,
	output int n_records,
	output int n_refills
);
	import frd_pkg::*;

	logic track_en;
	logic [15:0] interval_ms;
	logic [15:0] holdoff_ms;
	logic [6:0] spread_pct;
	logic [6:0] increase_pct;
	logic [6:0] decrease_pct;

	logic [6:0] levels [SampleDepth];
	int slot;
	int filled;
	logic [31:0] last_t;
	logic prev_ign;
	logic ign_seen;
	logic started;
	logic off_done;
	logic ckpt_valid;
	logic [6:0] ckpt_level;
	logic rf_valid;
	logic [6:0] rf_before;
	logic [6:0] rf_after;
	logic [23:0] rf_odo;

	rec_t due_records [$];
	rec_t run_records [$];

	initial begin
		errors = 0;
		pending = 0;
		n_ticks = 0;
		n_records = 0;
		n_refills = 0;
		track_en = 1'b0;
		interval_ms = 16'd1000;
		holdoff_ms = 16'd5000;
		spread_pct = 7'd2;
		increase_pct = 7'd10;
		decrease_pct = 7'd5;
		foreach (levels[i]) levels[i] = '0;
		slot = 0;
		filled = 0;
		last_t = '0;
		prev_ign = 1'b0;
		ign_seen = 1'b0;
		started = 1'b0;
		off_done = 1'b0;
		ckpt_valid = 1'b0;
		ckpt_level = '0;
		rf_valid = 1'b0;
		rf_before = '0;
		rf_after = '0;
		rf_odo = '0;
	end

	task automatic report(string what, int want, int got);
		$display("%0t record mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		errors++;
	endtask

	task automatic add_record(logic kind, logic [6:0] b, logic [6:0] a, logic [23:0] odo);
		rec_t r;
		if (run_records.size() > 0) run_records[run_records.size()-1].last_of_run = 1'b0;
		r.record_kind = kind;
		r.before_percent = b;
		r.after_percent = a;
		r.record_odometer = odo;
		r.last_of_run = 1'b1;
		run_records.push_back(r);
	endtask

	task automatic save_ckpt(logic [6:0] lvl, logic [23:0] odo);
		ckpt_valid = 1'b1;
		ckpt_level = lvl;
		add_record(KIND_CHECKPOINT, lvl, lvl, odo);
	endtask

	task automatic note_refill(logic [6:0] b, logic [6:0] a, logic [23:0] odo);
		int odo_gap;
		odo_gap = (rf_odo > odo) ? int'(rf_odo - odo) : int'(odo - rf_odo);
		if (rf_valid && rf_before == b && rf_after == a && odo_gap <= 10) return;
		rf_valid = 1'b1;
		rf_before = b;
		rf_after = a;
		rf_odo = odo;
		add_record(KIND_REFILL, b, a, odo);
	endtask

	// Median of a full ring whose spread is within the limit; -1 when not full or not stable.
	function automatic int stable_median();
		logic [6:0] s [SampleDepth];
		logic [6:0] tmp;
		if (filled < SampleDepth) return -1;
		s = levels;
		for (int i = 0; i < SampleDepth; i++)
			for (int j = 0; j < SampleDepth - 1 - i; j++)
				if (s[j] > s[j+1]) begin
					tmp = s[j];
					s[j] = s[j+1];
					s[j+1] = tmp;
				end
		if (int'(s[SampleDepth-1]) - int'(s[0]) > int'(spread_pct)) return -1;
		return int'(s[SampleDepth/2]);
	endfunction

	task automatic predict_tick(tick_t t);
		logic clock_ok;
		int lvl;
		run_records.delete();
		if (!track_en) return;
		clock_ok = t.year >= 2020 && t.year <= 2099 && t.month >= 1 && t.month <= 12
			&& t.day >= 1 && t.hour <= 23 && t.minute <= 59 && t.second <= 59;
		if (!clock_ok || t.fuel_level > 100 || t.time_ms <= {16'd0, holdoff_ms}) begin
			slot = 0;
			filled = 0;
			return;
		end
		if (!ign_seen) begin
			prev_ign = t.ignition;
			ign_seen = 1'b1;
		end else if (t.ignition != prev_ign) begin
			prev_ign = t.ignition;
			off_done = 1'b0;
			if (t.ignition) started = 1'b0;
			slot = 0;
			filled = 0;
			last_t = '0;
		end
		if (last_t != 0 && 32'(t.time_ms - last_t) < {16'd0, interval_ms}) return;
		last_t = t.time_ms;
		if (t.ignition) begin
			levels[slot] = t.fuel_level[6:0];
			slot = (slot + 1) % SampleDepth;
			if (filled < SampleDepth) filled++;
		end
		lvl = stable_median();
		if (lvl < 0) return;
		if (t.ignition && !started) begin
			if (!ckpt_valid) begin
				save_ckpt(7'(lvl), t.odometer);
			end else if (lvl >= int'(ckpt_level) + int'(increase_pct)) begin
				note_refill(ckpt_level, 7'(lvl), t.odometer);
				save_ckpt(7'(lvl), t.odometer);
			end else if (int'(ckpt_level) >= lvl + int'(decrease_pct)) begin
				save_ckpt(7'(lvl), t.odometer);
			end
			started = 1'b1;
		end else if (!t.ignition && !off_done) begin
			if (ckpt_valid && int'(ckpt_level) >= lvl + int'(decrease_pct))
				save_ckpt(7'(lvl), t.odometer);
			off_done = 1'b1;
		end
		foreach (run_records[i]) due_records.push_back(run_records[i]);
	endtask

	always @(posedge clk) begin
		rec_t want;
		if (we) begin
			case (reg_idx_t'(idx))
				REG_ENABLE: track_en = wdata[0];
				REG_INTERVAL: interval_ms = wdata;
				REG_HOLDOFF: holdoff_ms = wdata;
				REG_SPREAD: spread_pct = wdata[6:0];
				REG_INCREASE: increase_pct = wdata[6:0];
				REG_DECREASE: decrease_pct = wdata[6:0];
				default: ;
			endcase
		end
		if (tick.valid && tick.ready) begin
			n_ticks++;
			predict_tick(tick.data);
		end
		if (rec.valid && rec.ready) begin
			n_records++;
			if (rec.data.record_kind == KIND_REFILL) n_refills++;
			if (due_records.size() == 0) begin
				$display("%0t unexpected record beat", $realtime);
				errors++;
			end else begin
				want = due_records.pop_front();
				if (rec.data.record_kind != want.record_kind)
					report("kind", want.record_kind, rec.data.record_kind);
				if (rec.data.before_percent != want.before_percent)
					report("before", want.before_percent, rec.data.before_percent);
				if (rec.data.after_percent != want.after_percent)
					report("after", want.after_percent, rec.data.after_percent);
				if (rec.data.record_odometer != want.record_odometer)
					report("odometer", want.record_odometer, rec.data.record_odometer);
				if (rec.data.last_of_run != want.last_of_run)
					report("last flag", want.last_of_run, rec.data.last_of_run);
			end
		end
		pending = due_records.size();
	end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the fuel refill event detector testbench: clock, reset, register phases, tick
// stimulus and record back-pressure. Depends on frd_pkg, frd_if and frd_record_scoreboard.
module testbench;
	import frd_pkg::*;

	logic clk;
	logic arst_n;
	logic we;
	logic [CfgIdxW-1:0] idx;
	logic [CfgDataW-1:0] wdata;
	int errors;
	int pending;
	int n_ticks;
	int n_records;
	int n_refills;
	int hold_req;
	logic calm;
	logic [31:0] now_ms;
	logic [23:0] odo;
	logic [15:0] cur_interval;
	logic [6:0] cur_spread;

	frd_tick_if tick_ch ();
	frd_rec_if rec_ch ();

	fuel_refill_event_detector_core u_top (
		.clk(clk), .arst_n(arst_n), .tick(tick_ch), .rec(rec_ch),
		.we(we), .idx(idx), .wdata(wdata)
	);

	frd_record_scoreboard u_board (
		.clk(clk), .we(we), .idx(idx), .wdata(wdata), .tick(tick_ch), .rec(rec_ch),
		.errors(errors), .pending(pending), .n_ticks(n_ticks),
		.n_records(n_records), .n_refills(n_refills)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		rec_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold == 0 && !calm && $urandom_range(0, 99) == 0) hold = $urandom_range(15, 60);
			if (hold > 0) begin
				rec_ch.ready <= 1'b0;
				hold--;
			end else if (calm) begin
				rec_ch.ready <= 1'b1;
			end else begin
				rec_ch.ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 50);
	endfunction

	task automatic send(tick_t t);
		int g;
		g = gap_len();
		if (g > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.data <= t;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	task automatic drain();
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(logic en, logic [15:0] ival, logic [15:0] hoff,
			logic [6:0] spr, logic [6:0] inc, logic [6:0] dec);
		reg_idx_t order [6];
		logic [15:0] vals [6];
		order = '{REG_ENABLE, REG_INTERVAL, REG_HOLDOFF, REG_SPREAD, REG_INCREASE, REG_DECREASE};
		vals = '{{15'd0, en}, ival, hoff, {9'd0, spr}, {9'd0, inc}, {9'd0, dec}};
		for (int i = 0; i < 6; i++) begin
			we <= 1'b1;
			idx <= order[i];
			wdata <= vals[i];
			@(posedge clk);
		end
		we <= 1'b0;
		cur_interval = ival;
		cur_spread = spr;
		now_ms = {16'd0, hoff} + 32'd1 + $urandom_range(0, 1000);
	endtask

	function automatic tick_t good_tick(logic [31:0] t, logic [7:0] lvl, logic ign);
		tick_t k;
		k.time_ms = t;
		k.fuel_level = lvl;
		k.ignition = ign;
		k.odometer = odo;
		k.year = 12'($urandom_range(2020, 2099));
		k.month = 4'($urandom_range(1, 12));
		k.day = 5'($urandom_range(1, 31));
		k.hour = 5'($urandom_range(0, 23));
		k.minute = 6'($urandom_range(0, 59));
		k.second = 6'($urandom_range(0, 59));
		return k;
	endfunction

	// A run of well-formed samples, at least one interval apart, around one level.
	task automatic drive_trip(logic ign, int lvl, int n, int jitter);
		int v;
		for (int i = 0; i < n; i++) begin
			now_ms += {16'd0, cur_interval} + $urandom_range(0, 3);
			v = lvl + $urandom_range(0, jitter);
			if (v > 100) v = 100;
			send(good_tick(now_ms, 8'(v), ign));
			odo += 24'($urandom_range(0, 3));
		end
	endtask

	task automatic drive_random(int n_items);
		int k;
		int base;
		tick_t t;
		k = 0;
		base = $urandom_range(0, 100);
		while (k < n_items) begin
			case ($urandom_range(0, 9))
				0: begin
					t = tick_t'({$urandom, $urandom, $urandom});
					send(t);
					k++;
				end
				1: begin
					t = good_tick(now_ms + $urandom_range(0, 2), 8'($urandom_range(0, 100)),
						1'($urandom_range(0, 1)));
					send(t);
					k++;
				end
				2: begin
					drive_trip(1'b0, base, 2, 3);
					k += 2;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) base = $urandom_range(0, 100);
					else if ($urandom_range(0, 1) == 0) base = $urandom_range(0, 100 - base) + base;
					if ($urandom_range(0, 7) == 0) odo = 24'($urandom);
					drive_trip(1'b1, base, 5 + $urandom_range(0, 3),
						$urandom_range(0, int'(cur_spread) + 1));
					k += 5;
				end
			endcase
			if ($urandom_range(0, 7) == 0) calm = ~calm;
		end
	endtask

	initial begin
		tick_t t;
		arst_n = 1'b0;
		we = 1'b0;
		idx = '0;
		wdata = '0;
		hold_req = 0;
		calm = 1'b0;
		odo = 24'd1000;
		now_ms = '0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(1'b1, 16'd1000, 16'd5000, 7'd2, 7'd10, 7'd5);
		// Hold-off, broken wall clock and out-of-range level are all dropped.
		send(good_tick(32'd5000, 8'd50, 1'b1));
		t = good_tick(now_ms, 8'd50, 1'b1); t.year = 12'd2019; send(t);
		t = good_tick(now_ms, 8'd50, 1'b1); t.year = 12'd2100; send(t);
		t = good_tick(now_ms, 8'd50, 1'b1); t.month = 4'd13; t.day = 5'd0; send(t);
		t = good_tick(now_ms, 8'd50, 1'b1); t.hour = 5'd24; t.minute = 6'd60; send(t);
		t = good_tick(now_ms, 8'd50, 1'b1); t.second = 6'd60; send(t);
		send(good_tick(now_ms, 8'd101, 1'b1));
		send(good_tick(now_ms, 8'd255, 1'b1));
		// First checkpoint, then a refill after an ignition cycle.
		drive_trip(1'b1, 50, 5, 0);
		drive_trip(1'b0, 50, 1, 0);
		drive_trip(1'b1, 70, 5, 0);
		drive_trip(1'b0, 70, 1, 0);
		drive_trip(1'b1, 50, 5, 0);
		// A refill to about the same level again, suppressed only if it matches the last one near the same odometer.
		drive_trip(1'b0, 50, 1, 0);
		drive_trip(1'b1, 70, 5, 2);
		drive_trip(1'b1, 0, 1, 0);
		drive_trip(1'b1, 100, 1, 0);
		drain();

		write_regs(1'b1, 16'd1, 16'd0, 7'd0, 7'd1, 7'd1);
		hold_req = 400;
		calm = 1'b1;
		drive_random(130);
		calm = 1'b0;
		drain();
		write_regs(1'b1, 16'd65535, 16'd65535, 7'd100, 7'd100, 7'd100);
		drive_random(120);
		drain();
		write_regs(1'b0, 16'd1000, 16'd0, 7'd2, 7'd10, 7'd5);
		drive_random(30);
		drain();
		write_regs(1'b1, 16'd500, 16'd100, 7'd5, 7'd20, 7'd10);
		hold_req = 300;
		drive_random(130);
		drain();
		write_regs(1'b1, 16'd1, 16'd0, 7'd3, 7'd5, 7'd3);
		drive_random(130);
		drain();
		write_regs(1'b1, 16'd1000, 16'd5000, 7'd2, 7'd10, 7'd5);
		drive_random(130);
		drain();

		$display("Run covered %0d tick beats and %0d record beats, %0d of them refills,",
			n_ticks, n_records, n_refills);
		$display("over six register settings including both ends of every range.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
